>>> hdl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the CSV field splitter.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int MAX_FIELD_CHARS_DEF = 1024;
    localparam int FIELD_LIMIT_MAX_DEF = 1024;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [10:0] MAX_FIELDS_RESET = 11'd64;
    localparam logic [7:0]  QUOTE_BYTE       = 8'h22;
    localparam logic [7:0]  COMMA_BYTE       = 8'h2C;
    localparam logic [7:0]  NUL_BYTE         = 8'h00;

    typedef enum logic [1:0] {
        CLS_CHAR,
        CLS_QUOTE,
        CLS_COMMA,
        CLS_EOL
    } t_byte_class;

    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  data;
    } t_token;

    typedef enum logic [2:0] {
        KIND_CHAR      = 3'd0,
        KIND_FIELD_END = 3'd1,
        KIND_LINE_END  = 3'd2,
        KIND_UNCLOSED  = 3'd3,
        KIND_LIMIT     = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_out;
        logic [9:0]  field_index;
        logic        chars_were_dropped;
    } t_result;

endpackage

>>> hdl/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream of CSV lines into characters, field and line markers.
// ----------------------------------------------------------------------------
// One byte enters per cycle on the slave stream while s_tready is high; a
// zero byte ends the line. Each byte produces zero or one result word on
// the master stream after passing the classifier register, the token queue
// and the result register, at a sustained rate of one byte per clock while
// the output is not stalled. A four-word token queue between the classifier
// and the parser lets the input keep flowing while the output is briefly
// stalled. Quotes toggle quoted mode anywhere in a field, a doubled quote
// inside quotes gives one literal quote, unquoted commas end fields.
// Fields keep at most MAX_FIELD_CHARS-1 characters; more are dropped and
// flagged at the field end. After max_fields fields the line is cut off with
// a limit marker and the rest is dropped up to the zero byte. Write
// max_fields only while the block is idle.
module csv_field_splitter #(
    parameter int MAX_FIELD_CHARS = cfs_pkg::MAX_FIELD_CHARS_DEF,
    parameter int FIELD_LIMIT_MAX = cfs_pkg::FIELD_LIMIT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] char_out, [17:8] field_index,
                                    // [18] chars_were_dropped, rest zero
    output logic [2:0]  m_tuser,    // [2:0] kind
    // max_fields register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import cfs_pkg::*;

    // effective limit clamps to FIELD_LIMIT_MAX, which may exceed the register
    localparam int LIM_CAP = (FIELD_LIMIT_MAX > 2047) ? 2047 : FIELD_LIMIT_MAX;
    localparam logic [10:0] LIM_CAP_W = LIM_CAP[10:0];

    logic        r_max_fields;
    logic [10:0] r_max_fields_q;
    logic [10:0] field_limit;

    logic   fr_valid, fr_ready;
    t_token fr_tok;
    logic   q_valid, q_ready;
    t_token q_tok;
    t_result res;

    assign o_cfg_ready = 1'b1;

    // r_max_fields marks that the register was ever written (unused value
    // otherwise comes from reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields_q <= MAX_FIELDS_RESET;
            r_max_fields   <= 1'b0;
        end else if (i_cfg_valid) begin
            r_max_fields_q <= i_cfg_data;
            r_max_fields   <= 1'b1;
        end
    end

    // zero acts as one, large values clamp to the cap
    always_comb begin
        if (r_max_fields_q == 11'd0) begin
            field_limit = 11'd1;
        end else if (r_max_fields_q > LIM_CAP_W) begin
            field_limit = LIM_CAP_W;
        end else begin
            field_limit = r_max_fields_q;
        end
    end

    cfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_byte  (s_tdata),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_tok   (fr_tok)
    );

    cfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_tok   (fr_tok),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_tok   (q_tok)
    );

    cfs_back #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_field_limit (field_limit),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_tok         (q_tok),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_res         (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {5'd0, res.chars_were_dropped, res.field_index, res.char_out};

    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_max_fields && r_max_fields_q == $past(i_cfg_data)))
        else $error("max_fields write lost");

endmodule

>>> hdl/cfs_front.sv
// ----------------------------------------------------------------------------
// cfs_front
// Input stage: one byte a cycle unless stalled; classifies and registers it.
// ----------------------------------------------------------------------------
module cfs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    output logic            o_valid,
    input  logic            i_ready,
    output cfs_pkg::t_token o_tok
);
    import cfs_pkg::*;

    logic   r_valid;
    t_token r_tok;
    t_token n_tok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

    always_comb begin
        n_tok.data = i_byte;
        case (i_byte)
            QUOTE_BYTE: n_tok.cls = CLS_QUOTE;
            COMMA_BYTE: n_tok.cls = CLS_COMMA;
            NUL_BYTE:   n_tok.cls = CLS_EOL;
            default:    n_tok.cls = CLS_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tok <= n_tok;
        end
    end

endmodule

>>> hdl/cfs_queue.sv
// ----------------------------------------------------------------------------
// cfs_queue
// Short token FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module cfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cfs_pkg::t_token i_tok,
    output logic            o_valid,
    input  logic            i_ready,
    output cfs_pkg::t_token o_tok
);
    import cfs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/cfs_back.sv
// ----------------------------------------------------------------------------
// cfs_back
// Parser: quote/field/length state per token, registers at most one result.
// ----------------------------------------------------------------------------
module cfs_back #(
    parameter int MAX_FIELD_CHARS = cfs_pkg::MAX_FIELD_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [10:0]      i_field_limit,
    input  logic             i_valid,
    output logic             o_ready,
    input  cfs_pkg::t_token  i_tok,
    output logic             o_valid,
    input  logic             i_ready,
    output cfs_pkg::t_result o_res
);
    import cfs_pkg::*;

    localparam int CW = $clog2(MAX_FIELD_CHARS);
    localparam logic [CW-1:0] CHAR_MAX = CW'(MAX_FIELD_CHARS - 1);

    logic          r_in_quotes,     n_in_quotes;
    logic          r_quote_pending, n_quote_pending;
    logic [10:0]   r_field_number,  n_field_number;
    logic [CW-1:0] r_char_number,   n_char_number;
    logic          r_skipping,      n_skipping;
    logic          r_overflowed,    n_overflowed;
    logic          r_out_valid;
    t_result       r_res,           n_res;
    logic          emit;
    logic          take;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        logic q;
        logic done;
        logic line_end;
        logic keep;
        logic [7:0] kc;
        q    = r_in_quotes;
        done = 1'b0;
        line_end = 1'b0;
        keep = 1'b0;
        kc   = i_tok.data;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_field_number  = r_field_number;
        n_char_number   = r_char_number;
        n_skipping      = r_skipping;
        n_overflowed    = r_overflowed;
        emit = 1'b0;
        n_res.kind = KIND_CHAR;
        n_res.char_out = 8'd0;
        n_res.field_index = r_field_number[9:0];
        n_res.chars_were_dropped = 1'b0;

        if (take) begin
            if (r_skipping) begin
                if (i_tok.cls == CLS_EOL) begin
                    line_end = 1'b1;
                end else if (i_tok.cls == CLS_QUOTE) begin
                    n_in_quotes = !r_in_quotes;
                end
            end else begin
                // a quote seen in quoted mode: a second one is a literal
                if (r_quote_pending) begin
                    n_quote_pending = 1'b0;
                    if (i_tok.cls == CLS_QUOTE) begin
                        keep = 1'b1;
                        kc   = QUOTE_BYTE;
                        done = 1'b1;
                    end else begin
                        q = 1'b0;
                        n_in_quotes = 1'b0;
                    end
                end
                if (!done) begin
                    if (q) begin
                        case (i_tok.cls)
                            CLS_EOL:   line_end = 1'b1;
                            CLS_QUOTE: n_quote_pending = 1'b1;
                            default:   keep = 1'b1;
                        endcase
                    end else begin
                        case (i_tok.cls)
                            CLS_QUOTE: n_in_quotes = 1'b1;
                            CLS_EOL:   line_end = 1'b1;
                            CLS_COMMA: begin
                                emit = 1'b1;
                                n_res.chars_were_dropped = r_overflowed;
                                if ((r_field_number + 11'd1) >= i_field_limit) begin
                                    n_res.kind = KIND_LIMIT;
                                    n_skipping = 1'b1;
                                end else begin
                                    n_res.kind = KIND_FIELD_END;
                                    n_field_number = r_field_number + 11'd1;
                                end
                                n_char_number = '0;
                                n_overflowed  = 1'b0;
                            end
                            default:   keep = 1'b1;
                        endcase
                    end
                end
            end

            if (keep) begin
                if (r_char_number < CHAR_MAX) begin
                    n_char_number  = r_char_number + CW'(1);
                    emit           = 1'b1;
                    n_res.kind     = KIND_CHAR;
                    n_res.char_out = kc;
                end else begin
                    n_overflowed = 1'b1;
                end
            end

            if (line_end) begin
                emit = 1'b1;
                if (q) begin
                    n_res.kind = KIND_UNCLOSED;
                end else begin
                    n_res.kind = KIND_LINE_END;
                    n_res.chars_were_dropped = r_overflowed;
                end
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                n_field_number  = '0;
                n_char_number   = '0;
                n_skipping      = 1'b0;
                n_overflowed    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_field_number  <= '0;
            r_char_number   <= '0;
            r_skipping      <= 1'b0;
            r_overflowed    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_field_number  <= n_field_number;
            r_char_number   <= n_char_number;
            r_skipping      <= n_skipping;
            r_overflowed    <= n_overflowed;
            if (o_ready) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    a_pending_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote_pending |-> r_in_quotes)
        else $error("quote pending outside quoted mode");

    a_skip_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skipping |-> !r_quote_pending)
        else $error("quote pending while skipping");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflowed |-> (r_char_number == CHAR_MAX))
        else $error("overflow flagged with room left in field");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_res)))
        else $error("result changed while stalled");

endmodule

>>> dv/csv_field_splitter_test.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_test
// Self-checking bench for the CSV field splitter.
// ----------------------------------------------------------------------------
// Bytes of CSV lines are streamed into the block. Every accepted byte runs
// through a line parser model in this bench, and the words it predicts are
// queued. Each word leaving the block is matched against the oldest queued
// word. Directed tests cover plain and quoted fields, doubled quotes,
// unclosed quotes and the field count limit. Random lines follow under
// several max_fields settings. Both stream sides idle at random, and the
// result side once holds off long enough to back up the input.
module csv_field_splitter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tready    = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [10:0] i_cfg_data  = 11'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;    // [7:0] char_out, [17:8] field_index, [18] dropped
    logic [2:0]  m_tuser;    // [2:0] kind
    logic        o_cfg_ready;

    always #4 i_clk = ~i_clk;

    csv_field_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Line parser model: state mirrors the block after reset
    // ------------------------------------------------------------------
    logic [10:0] pm_max_fields    = MAX_FIELDS_RESET;
    logic        pm_in_quotes     = 1'b0;
    logic        pm_quote_pending = 1'b0;   // quote seen inside quotes
    logic        pm_skipping      = 1'b0;   // field limit hit, drop to EOL
    logic        pm_overflowed    = 1'b0;   // current field lost chars
    int          pm_field         = 0;
    int          pm_chars         = 0;

    t_result     parsed_q[$];               // words the block still owes
    int          mismatches       = 0;
    int          items_sent       = 0;

    // idling knobs, changed per test
    int          rx_stall_pct     = 20;
    int          tx_gap_pct       = 20;
    int          hold_request     = 0;      // one-shot long receiver stall

    function automatic t_result make_word(t_kind k, logic [7:0] ch, logic dropped);
        t_result w;
        w.kind               = k;
        w.char_out           = ch;
        w.field_index        = pm_field[9:0];
        w.chars_were_dropped = dropped;
        return w;
    endfunction

    // Zero byte: line end or unclosed quote, then all line state clears.
    function automatic void close_line(output t_result w);
        if (pm_in_quotes)
            w = make_word(KIND_UNCLOSED, NUL_BYTE, 1'b0);
        else
            w = make_word(KIND_LINE_END, NUL_BYTE, pm_overflowed);
        pm_in_quotes     = 1'b0;
        pm_quote_pending = 1'b0;
        pm_skipping      = 1'b0;
        pm_overflowed    = 1'b0;
        pm_field         = 0;
        pm_chars         = 0;
    endfunction

    // A field keeps at most MAX_FIELD_CHARS-1 chars; the rest are dropped.
    function automatic logic keep_char(input logic [7:0] ch, output t_result w);
        w = '0;
        if (pm_chars < MAX_FIELD_CHARS_DEF - 1) begin
            pm_chars++;
            w = make_word(KIND_CHAR, ch, 1'b0);
            return 1'b1;
        end
        pm_overflowed = 1'b1;
        return 1'b0;
    endfunction

    // Returns 1 when the byte yields a result word.
    function automatic logic parse_byte(input logic [7:0] b, output t_result w);
        int lim;
        w = '0;
        if (pm_skipping) begin
            // dropping to EOL, but quote parity still counts
            if (b == NUL_BYTE) begin
                close_line(w);
                return 1'b1;
            end
            if (b == QUOTE_BYTE)
                pm_in_quotes = !pm_in_quotes;
            return 1'b0;
        end
        if (pm_quote_pending) begin
            pm_quote_pending = 1'b0;
            if (b == QUOTE_BYTE)
                return keep_char(QUOTE_BYTE, w);
            pm_in_quotes = 1'b0;
        end
        if (pm_in_quotes) begin
            if (b == NUL_BYTE) begin
                close_line(w);
                return 1'b1;
            end
            if (b == QUOTE_BYTE) begin
                pm_quote_pending = 1'b1;
                return 1'b0;
            end
            return keep_char(b, w);
        end
        if (b == QUOTE_BYTE) begin
            pm_in_quotes = 1'b1;
            return 1'b0;
        end
        if (b == NUL_BYTE) begin
            close_line(w);
            return 1'b1;
        end
        if (b == COMMA_BYTE) begin
            // register value 0 acts as 1, large values clamp
            lim = (pm_max_fields == 11'd0) ? 1 : int'(pm_max_fields);
            if (lim > FIELD_LIMIT_MAX_DEF)
                lim = FIELD_LIMIT_MAX_DEF;
            if (pm_field + 1 >= lim) begin
                w = make_word(KIND_LIMIT, NUL_BYTE, pm_overflowed);
                pm_skipping = 1'b1;
            end else begin
                w = make_word(KIND_FIELD_END, NUL_BYTE, pm_overflowed);
                pm_field++;
            end
            pm_chars      = 0;
            pm_overflowed = 1'b0;
            return 1'b1;
        end
        return keep_char(b, w);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Handshake monitor: predicts on accepted bytes, checks result words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (parsed_q.size() == 0) begin
                    flag_error($sformatf("unexpected word kind %0d tdata %06h",
                                         m_tuser, m_tdata));
                end else begin
                    w = parsed_q.pop_front();
                    if (m_tuser !== w.kind || m_tdata[7:0] !== w.char_out ||
                        m_tdata[17:8] !== w.field_index ||
                        m_tdata[18] !== w.chars_were_dropped ||
                        m_tdata[23:19] !== 5'd0)
                        flag_error($sformatf(
                            "exp kind %0d char %02h field %0d drop %0b, got %0d %02h %0d %0b pad %0h",
                            w.kind, w.char_out, w.field_index, w.chars_were_dropped,
                            m_tuser, m_tdata[7:0], m_tdata[17:8], m_tdata[18],
                            m_tdata[23:19]));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                pm_max_fields = i_cfg_data;
            if (s_tvalid && s_tready) begin
                if (parse_byte(s_tdata, w))
                    parsed_q.push_back(w);
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int span;
        stall_left = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            span = 1;
            if (hold_request > 0) begin
                span         = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < rx_stall_pct)
                    stall_left = pick_gap();
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------
    // Offer one byte, wait for the handshake, maybe idle afterwards.
    // tvalid stays high across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);   // junk while idle
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(NUL_BYTE);
    endtask

    // Stop offering, wait for every owed word, then let the pipe settle
    // (bytes that yield no word may still be in flight).
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (parsed_q.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic write_max_fields(input logic [10:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == QUOTE_BYTE || c == COMMA_BYTE);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset value of max_fields: a 67-field line is cut at field 63.
    task automatic test_default_limit();
        repeat (66) begin
            send_byte("x");
            send_byte(COMMA_BYTE);
        end
        send_byte(NUL_BYTE);
        drain();
    endtask

    task automatic test_plain_fields();
        send_line("ab,,c");
        send_line("");                  // empty line: lone zero byte
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(COMMA_BYTE);
        send_byte(NUL_BYTE);
        drain();
    endtask

    task automatic test_quoting();
        send_line("\"x,y\",z");         // comma inside quotes is data
        send_line("\"a\"\"b\"");        // doubled quote gives one quote
        send_line("ab\"c,d\"e");        // quote opens mid field
        send_line("\"abc");             // unclosed at line end
        send_line("\"ab\"");            // pending quote closed by zero byte
        drain();
    endtask

    task automatic test_field_limits();
        write_max_fields(11'd0);        // acts as 1
        send_line("a,b\"c,d");          // odd quotes while skipping
        drain();
        write_max_fields(11'd1);
        send_line("a,\"\"b,c");         // even quotes while skipping
        drain();
        write_max_fields(11'd3);
        send_line("a,b,c,d,e");
        drain();
        write_max_fields(11'd2047);     // clamps to the top limit
        send_line("a,b");
        drain();
        write_max_fields(11'd1025);
        send_line("a,b");
        drain();
    endtask

    // Long receiver hold-off while bytes keep coming: input must stall.
    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_max_fields(MAX_FIELDS_RESET);
        hold_request = 80;
        repeat (40) send_byte(plain_char());
        send_byte(COMMA_BYTE);
        send_line("tail");
        drain();
    endtask

    task automatic send_random_line();
        int nf;
        if ($urandom_range(0, 9) == 0) begin
            // noise: any byte, zeros included
            repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            nf = $urandom_range(1, 8);
            for (int f = 0; f < nf; f++) begin
                if (f > 0)
                    send_byte(COMMA_BYTE);
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        repeat ($urandom_range(1, 5)) send_byte(plain_char());
                    end else begin
                        send_byte(QUOTE_BYTE);
                        repeat ($urandom_range(0, 6)) begin
                            case ($urandom_range(0, 5))
                                0: send_byte(COMMA_BYTE);
                                1: begin
                                    send_byte(QUOTE_BYTE);
                                    send_byte(QUOTE_BYTE);
                                end
                                default: send_byte(plain_char());
                            endcase
                        end
                        // now and then leave the quote open
                        if ($urandom_range(0, 19) != 0)
                            send_byte(QUOTE_BYTE);
                    end
                end
            end
        end
        send_byte(NUL_BYTE);
    endtask

    task automatic test_random();
        int start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_max_fields(11'($urandom_range(1, 4)));
                1: write_max_fields(11'($urandom_range(0, 2047)));
                2: write_max_fields(11'($urandom_range(5, 12)));
                default: write_max_fields(MAX_FIELDS_RESET);
            endcase
            // first phase runs without any idling
            rx_stall_pct = (ph == 0) ? 0 : $urandom_range(15, 50);
            tx_gap_pct   = (ph == 0) ? 0 : $urandom_range(15, 50);
            start = items_sent;
            while (items_sent - start < 45)
                send_random_line();
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_limit();
        test_plain_fields();
        test_quoting();
        test_field_limits();
        test_backpressure();
        test_random();
        if (parsed_q.size() != 0)
            flag_error($sformatf("%0d words never arrived", parsed_q.size()));
        if (mismatches == 0)
            $display("csv_field_splitter verification clean");
        else
            $display("csv_field_splitter verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("csv_field_splitter verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/cfs_pkg.sv
hdl/cfs_front.sv
hdl/cfs_queue.sv
hdl/cfs_back.sv
hdl/csv_field_splitter.sv
dv/csv_field_splitter_test.sv
